// ----- hw/rtl/task_ring_writer_defines.svh -----
// Assertion macros for the checker file of the task ring writer.
// Each macro attaches one concurrent property to the given clock and
// active-low reset, and reports a failure with the given message.
`ifndef TASK_RING_WRITER_DEFINES_SVH
`define TASK_RING_WRITER_DEFINES_SVH

// Same-cycle implication.
`define TRW_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TRW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/trw_pkg.sv -----
package trw_pkg;

    localparam int WORD_W = 64;
    localparam int SLOT_W = 10;
    localparam int OP_W   = 2;
    localparam int CNT8_W = 8;
    // Record sizes reach 4 + 255 + 255 + 3 * 255 = 1279.
    localparam int SIZE_W = 11;

    localparam logic [OP_W-1:0] OP_STREAM = 2'd0;
    localparam logic [OP_W-1:0] OP_CWRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CREAD  = 2'd2;

    localparam logic [7:0]        MARK_FREE      = 8'h00;
    localparam logic [7:0]        VALID_MARK     = 8'h80;
    localparam logic [WORD_W-1:0] PLACEHOLDER_ID = 64'hFFFF44446666AAAA;

    localparam logic [SIZE_W-1:0] HEADER_WORDS = 11'd4;

    typedef logic [SIZE_W-1:0] size_t;

    // Body words of a record: arguments, dependencies and three words per copy.
    function automatic size_t body_words(logic [CNT8_W-1:0] args,
                                         logic [CNT8_W-1:0] deps,
                                         logic [CNT8_W-1:0] copies);
        size_t c3;
        c3 = {SIZE_W'(copies), 1'b0}[SIZE_W-1:0] + SIZE_W'(copies);
        return SIZE_W'(args) + SIZE_W'(deps) + c3;
    endfunction

    // Full slot count of the record described by a first header word.
    function automatic size_t record_size(logic [WORD_W-1:0] w);
        return HEADER_WORDS + body_words(w[15:8], w[23:16], w[31:24]);
    endfunction

endpackage

// ----- hw/rtl/task_ring_writer.sv -----
// Task ring writer.
// The s_ channel carries one beat per operation: s_op selects a producer
// stream word, a consumer slot write or a consumer slot read; s_word and
// s_slot are its data. The m_ channel returns exactly one beat for every
// input beat, in order: accepted/oversize for stream words, published and
// task_start when a record was just marked valid, read_word for reads.
// A first header word may first reclaim consumed records at the read
// pointer; each reclaim step is a memory read and a check of the
// returned header. The last word of a record is followed by the four
// header writes, the ring memory taking one write per cycle. A consumer
// write or read first subtracts the ring length from the slot index, one
// subtraction at a time, as long as the index is not below the ring length.
// One item is worked on at a time; the next beat is taken as soon as the
// previous result sits in the output register, even if the receiver has
// not yet taken it. When the receiver stalls, the output register holds
// its beat and a finished result waits until the register frees up.
// Reset returns the control state (pointers, free count, header phase,
// handshakes) at once; the ring memory is left as it is and has no
// clearing pass.
module task_ring_writer
    import trw_pkg::*;
#(
    parameter int RING_SLOTS = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [WORD_W-1:0] s_word,
    input  logic [SLOT_W-1:0] s_slot,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_accepted,
    output logic              m_published,
    output logic [SLOT_W-1:0] m_task_start,
    output logic [WORD_W-1:0] m_read_word,
    output logic              m_oversize
);

    localparam int PTR_W = $clog2(RING_SLOTS);
    localparam int CNT_W = $clog2(RING_SLOTS + 1);
    localparam int SUM_W = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SLOT   = 3'd1;
    localparam logic [2:0] ST_RDATA  = 3'd2;
    localparam logic [2:0] ST_STREAM = 3'd3;
    localparam logic [2:0] ST_RECL   = 3'd4;
    localparam logic [2:0] ST_PUB    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // Record phases: which word of the record the producer sends next.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    localparam logic [1:0] PUB_LAST = 2'd3;

    // Ring position base + off, where the sum stays below twice the ring.
    function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base, size_t off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(RING_SLOTS)) begin
            sum = sum - SUM_W'(RING_SLOTS);
        end
        return PTR_W'(sum);
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [CNT8_W-1:0] args_reg, args_next;
    logic [CNT8_W-1:0] deps_reg, deps_next;
    logic [CNT8_W-1:0] copies_reg, copies_next;
    size_t             pos_reg, pos_next;
    logic [1:0]        pub_cnt_reg, pub_cnt_next;
    logic [WORD_W-1:0] hold0_reg, hold0_next;
    logic [WORD_W-1:0] hold1_reg, hold1_next;
    logic [WORD_W-1:0] hold2_reg, hold2_next;

    // Result being built for the current item.
    logic              res_acc_reg, res_acc_next;
    logic              res_pub_reg, res_pub_next;
    logic [SLOT_W-1:0] res_start_reg, res_start_next;
    logic [WORD_W-1:0] res_read_reg, res_read_next;
    logic              res_over_reg, res_over_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic              m_acc_reg, m_acc_next;
    logic              m_pub_reg, m_pub_next;
    logic [SLOT_W-1:0] m_start_reg, m_start_next;
    logic [WORD_W-1:0] m_read_reg, m_read_next;
    logic              m_over_reg, m_over_next;

    // Ring memory with one write and one registered read port.
    logic [WORD_W-1:0] ring_mem [RING_SLOTS];
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PTR_W-1:0]  mem_raddr;
    logic [WORD_W-1:0] rd_data_reg;

    size_t             needed;
    size_t             body_len;
    size_t             rec_size;
    size_t             hdr_size;
    logic [CNT_W-1:0]  used_slots;
    size_t             pos_inc;
    logic [SUM_W-1:0]  free_left;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= ring_mem[mem_raddr];
        end
    end

    assign needed     = record_size(word_reg);
    assign body_len   = body_words(args_reg, deps_reg, copies_reg);
    assign rec_size   = HEADER_WORDS + body_len;
    assign hdr_size   = record_size(rd_data_reg);
    assign used_slots = CNT_W'(RING_SLOTS) - free_reg;
    assign pos_inc    = pos_reg + 1'b1;
    assign free_left  = SUM_W'(free_reg) - SUM_W'(rec_size);

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        slot_next      = slot_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        free_next      = free_reg;
        args_next      = args_reg;
        deps_next      = deps_reg;
        copies_next    = copies_reg;
        pos_next       = pos_reg;
        pub_cnt_next   = pub_cnt_reg;
        hold0_next     = hold0_reg;
        hold1_next     = hold1_reg;
        hold2_next     = hold2_reg;
        res_acc_next   = res_acc_reg;
        res_pub_next   = res_pub_reg;
        res_start_next = res_start_reg;
        res_read_next  = res_read_reg;
        res_over_next  = res_over_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_acc_next     = m_acc_reg;
        m_pub_next     = m_pub_reg;
        m_start_next   = m_start_reg;
        m_read_next    = m_read_reg;
        m_over_next    = m_over_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = word_reg;
        mem_re         = 1'b0;
        mem_raddr      = rp_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_op;
                    word_next      = s_word;
                    slot_next      = s_slot;
                    res_acc_next   = 1'b0;
                    res_pub_next   = 1'b0;
                    res_start_next = '0;
                    res_read_next  = '0;
                    res_over_next  = 1'b0;
                    unique case (s_op) inside
                        OP_STREAM:          state_next = ST_STREAM;
                        OP_CWRITE, OP_CREAD: state_next = ST_SLOT;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SLOT: begin
                // Bring the slot index into the ring, one subtraction a cycle.
                if (32'(slot_reg) >= RING_SLOTS) begin
                    slot_next = slot_reg - SLOT_W'(RING_SLOTS);
                end else if (op_reg == OP_CWRITE) begin
                    mem_we     = 1'b1;
                    mem_waddr  = PTR_W'(slot_reg);
                    mem_wdata  = word_reg;
                    state_next = ST_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = PTR_W'(slot_reg);
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA: begin
                res_read_next = rd_data_reg;
                state_next    = ST_DONE;
            end
            ST_STREAM: begin
                unique case (phase_reg)
                    PH_FIRST: begin
                        if (SUM_W'(needed) > SUM_W'(RING_SLOTS)) begin
                            res_acc_next  = 1'b1;
                            res_over_next = 1'b1;
                            state_next    = ST_DONE;
                        end else if (SUM_W'(needed) > SUM_W'(free_reg)) begin
                            mem_re     = 1'b1;
                            mem_raddr  = rp_reg;
                            state_next = ST_RECL;
                        end else begin
                            hold0_next   = word_reg;
                            args_next    = word_reg[15:8];
                            deps_next    = word_reg[23:16];
                            copies_next  = word_reg[31:24];
                            pos_next     = '0;
                            phase_next   = PH_SECOND;
                            res_acc_next = 1'b1;
                            state_next   = ST_DONE;
                        end
                    end
                    PH_SECOND: begin
                        hold1_next   = word_reg;
                        phase_next   = PH_THIRD;
                        res_acc_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    PH_THIRD: begin
                        hold2_next   = word_reg;
                        res_acc_next = 1'b1;
                        if (body_len == '0) begin
                            pub_cnt_next = '0;
                            state_next   = ST_PUB;
                        end else begin
                            phase_next = PH_BODY;
                            state_next = ST_DONE;
                        end
                    end
                    PH_BODY: begin
                        mem_we       = 1'b1;
                        mem_waddr    = wrap_add(wp_reg, pos_reg + HEADER_WORDS);
                        mem_wdata    = word_reg;
                        pos_next     = pos_inc;
                        res_acc_next = 1'b1;
                        if (pos_inc >= body_len) begin
                            pub_cnt_next = '0;
                            state_next   = ST_PUB;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_RECL: begin
                // Header at the read pointer is back from memory.
                if (rd_data_reg[63:56] != MARK_FREE
                        || SUM_W'(hdr_size) > SUM_W'(used_slots)) begin
                    state_next = ST_DONE;
                end else begin
                    free_next  = free_reg + CNT_W'(hdr_size);
                    rp_next    = wrap_add(rp_reg, hdr_size);
                    state_next = ST_STREAM;
                end
            end
            ST_PUB: begin
                mem_we       = 1'b1;
                pub_cnt_next = pub_cnt_reg + 1'b1;
                case (pub_cnt_reg)
                    2'd0: begin
                        mem_waddr = wrap_add(wp_reg, SIZE_W'(1));
                        mem_wdata = PLACEHOLDER_ID;
                    end
                    2'd1: begin
                        mem_waddr = wrap_add(wp_reg, SIZE_W'(2));
                        mem_wdata = hold1_reg;
                    end
                    2'd2: begin
                        mem_waddr = wrap_add(wp_reg, SIZE_W'(3));
                        mem_wdata = hold2_reg;
                    end
                    default: begin
                        mem_waddr = wp_reg;
                        mem_wdata = hold0_reg | {VALID_MARK, 56'd0};
                    end
                endcase
                if (pub_cnt_reg == PUB_LAST) begin
                    wp_next        = wrap_add(wp_reg, rec_size);
                    free_next      = (SUM_W'(rec_size) <= SUM_W'(free_reg))
                                   ? CNT_W'(free_left) : '0;
                    phase_next     = PH_FIRST;
                    pos_next       = '0;
                    res_pub_next   = 1'b1;
                    res_start_next = SLOT_W'(wp_reg);
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_acc_next   = res_acc_reg;
                    m_pub_next   = res_pub_reg;
                    m_start_next = res_start_reg;
                    m_read_next  = res_read_reg;
                    m_over_next  = res_over_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FIRST;
            wp_reg      <= '0;
            rp_reg      <= '0;
            free_reg    <= CNT_W'(RING_SLOTS);
            args_reg    <= '0;
            deps_reg    <= '0;
            copies_reg  <= '0;
            pos_reg     <= '0;
            pub_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            free_reg    <= free_next;
            args_reg    <= args_next;
            deps_reg    <= deps_next;
            copies_reg  <= copies_next;
            pos_reg     <= pos_next;
            pub_cnt_reg <= pub_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        word_reg      <= word_next;
        slot_reg      <= slot_next;
        hold0_reg     <= hold0_next;
        hold1_reg     <= hold1_next;
        hold2_reg     <= hold2_next;
        res_acc_reg   <= res_acc_next;
        res_pub_reg   <= res_pub_next;
        res_start_reg <= res_start_next;
        res_read_reg  <= res_read_next;
        res_over_reg  <= res_over_next;
        m_acc_reg     <= m_acc_next;
        m_pub_reg     <= m_pub_next;
        m_start_reg   <= m_start_next;
        m_read_reg    <= m_read_next;
        m_over_reg    <= m_over_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_accepted   = m_acc_reg;
    assign m_published  = m_pub_reg;
    assign m_task_start = m_start_reg;
    assign m_read_word  = m_read_reg;
    assign m_oversize   = m_over_reg;

endmodule

// ----- hw/rtl/trw_checker.sv -----
`include "task_ring_writer_defines.svh"

module trw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_accepted,
    input logic        m_published,
    input logic [9:0]  m_task_start,
    input logic [63:0] m_read_word,
    input logic        m_oversize
);

    // A stalled result beat keeps its contents.
    `TRW_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_accepted) && $stable(m_published) && $stable(m_task_start) && $stable(m_read_word) && $stable(m_oversize), "result beat changed while stalled")

    // No result can appear in the cycle right after an input beat is taken.
    `TRW_ASSERT_NEXT(a_min_latency, aclk, aresetn, s_valid && s_ready && !m_valid, !m_valid, "result beat appeared too early")

    // A dropped oversize header is consumed but never publishes anything.
    `TRW_ASSERT_IMPL(a_oversize_drop, aclk, aresetn, m_valid && m_oversize, m_accepted && !m_published, "oversize beat flags inconsistent")

    // Publishing only happens on a word that was taken.
    `TRW_ASSERT_IMPL(a_publish_taken, aclk, aresetn, m_valid && m_published, m_accepted && !m_oversize, "published beat not accepted")

endmodule

bind task_ring_writer trw_checker u_trw_checker (.*);
